// File: rtl/wrst_pkg.sv
// shared types and constants of the weighted random service table
package wrst_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W         = 32;
  localparam int TYPE_W        = 3;
  localparam int RATING_W      = 8;
  localparam int RND_W         = 16;
  localparam int STATUS_W      = 3;
  localparam int POS_W         = 4;
  // sum of all ratings stays below 2**(RATING_W + IDX_W)
  localparam int SUM_W         = RATING_W + IDX_W;
  localparam int MCNT_W        = $clog2(RND_W + 1);

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_SELECT = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 3'd0,
    STATUS_DUP      = 3'd1,
    STATUS_FULL     = 3'd2,
    STATUS_NOTFOUND = 3'd3,
    STATUS_NONE     = 3'd4
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIND  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_SUM   = 6'b001000,
    S_MOD   = 6'b010000,
    S_PICK  = 6'b100000
  } state_t;

  typedef struct packed {
    logic start;
  } mod_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_sts_t;

endpackage

// File: rtl/wrst_modulo.sv
// bit-serial restoring modulo unit, one dividend bit per cycle
module wrst_modulo import wrst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  mod_ctl_t         ctl,
  input  logic [RND_W-1:0] dividend,
  input  logic [SUM_W-1:0] divisor,
  output mod_sts_t         sts,
  output logic [SUM_W-1:0] remainder
);

  logic [RND_W-1:0]  dvd_r, dvd_nxt;
  logic [SUM_W-1:0]  div_r, div_nxt;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [MCNT_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    diff;

  assign trial = {rem_r, dvd_r[RND_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      dvd_nxt = dividend;
      div_nxt = divisor;
      rem_nxt = '0;
      cnt_nxt = MCNT_W'(RND_W);
    end else if (cnt_r != '0) begin
      dvd_nxt = {dvd_r[RND_W-2:0], 1'b0};
      // remainder stays below the divisor, so the top bit drops out
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = diff[SUM_W-1:0];
      end else begin
        rem_nxt = trial[SUM_W-1:0];
      end
      cnt_nxt = cnt_r - MCNT_W'(1);
      if (cnt_r == MCNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy  = (cnt_r != '0);
  assign sts.done  = done_r;
  assign remainder = rem_r;

endmodule

// File: rtl/weighted_random_service_table_unit.sv
// top level of the weighted random service table
//
//  channel | ports                                              | handshake
//  --------+----------------------------------------------------+--------------------------
//  input   | in_mode in_key in_service_type in_rating           | start && !busy
//          | in_random_value                                    |
//  result  | out_status out_picked_key out_picked_position      | out_valid, one cycle
//
// clear empties the table without leaving idle; add and remove run the key scan,
// which reads one entry a cycle (a remove match carries on as the shift walk);
// select runs the sum walk, the serial modulo and the pick walk in that order
// reset (synchronous, active low) empties the table; entry contents are not cleared
// busy stays high until the result strobe; the receiver cannot stall a result
module weighted_random_service_table_unit import wrst_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_mode,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [TYPE_W-1:0]   in_service_type,
  input  logic [RATING_W-1:0] in_rating,
  input  logic [RND_W-1:0]    in_random_value,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [KEY_W-1:0]    out_picked_key,
  output logic [POS_W-1:0]    out_picked_position
);

  logic [KEY_W-1:0]    key_mem_r    [TABLE_ENTRIES];
  logic [TYPE_W-1:0]   type_mem_r   [TABLE_ENTRIES];
  logic [RATING_W-1:0] rating_mem_r [TABLE_ENTRIES];

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  mode_t               mode_r, mode_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [TYPE_W-1:0]   type_r, type_nxt;
  logic [RATING_W-1:0] rating_r, rating_nxt;
  logic [RND_W-1:0]    rnd_r, rnd_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [KEY_W-1:0]    out_key_r, out_key_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [KEY_W-1:0]    wr_key;
  logic [TYPE_W-1:0]   wr_type;
  logic [RATING_W-1:0] wr_rating;

  logic [CNT_W-1:0]    idx_inc;
  logic [IDX_W-1:0]    rd_addr;
  logic [KEY_W-1:0]    rd_key;
  logic [TYPE_W-1:0]   rd_type;
  logic [RATING_W-1:0] rd_rating;
  logic                rd_eligible;
  logic                at_end;
  logic                accept;

  mod_ctl_t            mod_ctl;
  mod_sts_t            mod_sts;
  logic [SUM_W-1:0]    mod_rem;

  assign accept  = start && (state_r == S_IDLE);
  assign idx_inc = idx_r + CNT_W'(1);
  // the shift walk reads one entry ahead of the one it writes
  assign rd_addr = (state_r == S_SHIFT) ? idx_inc[IDX_W-1:0] : idx_r[IDX_W-1:0];
  assign rd_key      = key_mem_r[rd_addr];
  assign rd_type     = type_mem_r[rd_addr];
  assign rd_rating   = rating_mem_r[rd_addr];
  assign rd_eligible = (rd_type == type_r) && (rd_rating != '0);
  assign at_end      = (idx_r == count_r);

  wrst_modulo u_modulo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mod_ctl),
    .dividend  (rnd_r),
    .divisor   (acc_r),
    .sts       (mod_sts),
    .remainder (mod_rem)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    acc_nxt        = acc_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    type_nxt       = type_r;
    rating_nxt     = rating_r;
    rnd_nxt        = rnd_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_pos_nxt    = out_pos_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r[IDX_W-1:0];
    wr_key         = rd_key;
    wr_type        = rd_type;
    wr_rating      = rd_rating;
    mod_ctl.start  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt   = mode_t'(in_mode);
          key_nxt    = in_key;
          type_nxt   = in_service_type;
          rating_nxt = in_rating;
          rnd_nxt    = in_random_value;
          idx_nxt    = '0;
          acc_nxt    = '0;
          case (mode_t'(in_mode))
            MODE_ADD:    state_nxt = S_FIND;
            MODE_REMOVE: state_nxt = S_FIND;
            MODE_SELECT: state_nxt = S_SUM;
            default: begin
              count_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = STATUS_OK;
              out_key_nxt    = '0;
              out_pos_nxt    = '0;
            end
          endcase
        end
      end

      S_FIND: begin
        if (at_end) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_key_nxt   = '0;
          out_pos_nxt   = '0;
          if (mode_r == MODE_REMOVE) begin
            out_status_nxt = STATUS_NOTFOUND;
          end else if (count_r == CNT_W'(TABLE_ENTRIES)) begin
            out_status_nxt = STATUS_FULL;
          end else begin
            wr_en          = 1'b1;
            wr_addr        = count_r[IDX_W-1:0];
            wr_key         = key_r;
            wr_type        = type_r;
            wr_rating      = rating_r;
            count_nxt      = count_r + CNT_W'(1);
            out_status_nxt = STATUS_OK;
          end
        end else if (rd_key == key_r) begin
          if (mode_r == MODE_REMOVE) begin
            state_nxt = S_SHIFT;
          end else begin
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_DUP;
            out_key_nxt    = '0;
            out_pos_nxt    = '0;
          end
        end else begin
          idx_nxt = idx_inc;
        end
      end

      S_SHIFT: begin
        if (idx_inc < count_r) begin
          wr_en   = 1'b1;
          idx_nxt = idx_inc;
        end else begin
          count_nxt      = count_r - CNT_W'(1);
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_OK;
          out_key_nxt    = '0;
          out_pos_nxt    = '0;
        end
      end

      S_SUM: begin
        if (at_end) begin
          if (acc_r == '0) begin
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_NONE;
            out_key_nxt    = '0;
            out_pos_nxt    = '0;
          end else begin
            mod_ctl.start = 1'b1;
            state_nxt     = S_MOD;
          end
        end else begin
          if (rd_eligible) begin
            acc_nxt = acc_r + SUM_W'(rd_rating);
          end
          idx_nxt = idx_inc;
        end
      end

      S_MOD: begin
        if (mod_sts.done) begin
          acc_nxt   = mod_rem;
          idx_nxt   = '0;
          state_nxt = S_PICK;
        end
      end

      S_PICK: begin
        if (at_end) begin
          // the remainder is below the sum, so this arm is never reached
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_NONE;
          out_key_nxt    = '0;
          out_pos_nxt    = '0;
        end else if (rd_eligible && (acc_r < SUM_W'(rd_rating))) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_OK;
          out_key_nxt    = rd_key;
          out_pos_nxt    = POS_W'(idx_r);
        end else begin
          if (rd_eligible) begin
            acc_nxt = acc_r - SUM_W'(rd_rating);
          end
          idx_nxt = idx_inc;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem_r[wr_addr]    <= wr_key;
      type_mem_r[wr_addr]   <= wr_type;
      rating_mem_r[wr_addr] <= wr_rating;
    end
    idx_r        <= idx_nxt;
    acc_r        <= acc_nxt;
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    type_r       <= type_nxt;
    rating_r     <= rating_nxt;
    rnd_r        <= rnd_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_pos_r    <= out_pos_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_picked_key      = out_key_r;
  assign out_picked_position = out_pos_r;

  // the table never holds more entries than it has room for
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  // an accepted transaction other than clear keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode != MODE_CLEAR)) |=> busy)
    else $error("accepted transaction did not start work");

  // the result strobe comes only once the sequencer is back at rest
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // a failed transaction carries no picked entry
  a_pick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STATUS_OK)) |->
      ((out_picked_key == '0) && (out_picked_position == '0)))
    else $error("picked entry on a failed transaction");

  // the modulo unit is only in use during the modulo phase
  a_mod_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mod_sts.busy |-> (state_r == S_MOD))
    else $error("modulo unit running outside its phase");

endmodule
